FILE: design/eti_ni_frame_checker_defines.svh
// Shared assertion macros for the frame checker
`ifndef ETI_NI_FRAME_CHECKER_DEFINES_SVH
`define ETI_NI_FRAME_CHECKER_DEFINES_SVH

// Condition must never hold outside reset
`define ETI_FC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("eti_fc: forbidden condition");

// Condition a in one cycle requires b in the next
`define ETI_FC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("eti_fc: expected follow-up missing");

`endif

FILE: design/eti_fc_pkg.sv
package eti_fc_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_FIB    = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ABORT  = 2'd3;

    localparam logic [7:0]  ERR_NONE   = 8'hFF;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [23:0] FSYNC_EVEN = 24'h073AB6;
    localparam logic [23:0] FSYNC_ODD  = 24'hF8C549;

    localparam logic [1:0] SYNC_NONE = 2'd0;
    localparam logic [1:0] SYNC_EVEN = 2'd1;
    localparam logic [1:0] SYNC_ODD  = 2'd2;

    // Position arithmetic width: covers frame end plus stream total
    localparam int POS_W = 22;
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [1:0]  report_kind;
        logic        sync_error;
        logic        fsync_ok;
        logic [7:0]  frame_count;
        logic        fic_flag;
        logic [6:0]  stream_count;
        logic [2:0]  frame_phase;
        logic [1:0]  mode_id;
        logic [10:0] frame_length;
        logic        crc_ok;
        logic [1:0]  fib_index;
        logic [31:0] timestamp;
    } t_report;

    typedef struct packed {
        logic    push;
        t_report report;
    } t_push;

    // CRC-16 CCITT, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: design/eti_fc_front.sv
`include "eti_ni_frame_checker_defines.svh"

module eti_fc_front #(
    parameter int FRAME_BYTES = 6144
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_first,
    input  logic               i_frame_last,
    input  logic               i_continue,
    output eti_fc_pkg::t_push  o_push
);

    localparam int BP_W = $clog2(FRAME_BYTES + 1);
    localparam int POS_W = eti_fc_pkg::POS_W;

    logic [BP_W-1:0] r_pos, n_pos;
    logic [1:0]  r_sync, n_sync;
    logic [15:0] r_hcrc, n_hcrc, r_fcrc, n_fcrc;
    logic [31:0] r_hf, n_hf;
    logic [19:0] r_sbt, n_sbt;
    logic [1:0]  r_lhb, n_lhb;
    logic [7:0]  r_fibc, n_fibc, r_rch, n_rch;
    logic [31:0] r_ts, n_ts;
    logic [1:0]  r_flags, n_flags;
    logic        r_halted, n_halted, r_open, n_open, r_mst, n_mst;

    logic [POS_W-1:0] p, hdr_end, fic_end, mst_end, ficl4;
    logic [6:0]  nst;
    logic [23:0] w;
    logic        is_a, is_c, sync_ok;
    logic        rep_v, rep_crc;
    logic [1:0]  rep_kind, rep_fib;
    logic [31:0] rep_ts, ts_shift;
    logic [15:0] got;

    // Classify the byte and advance the frame state
    always_comb begin
        n_pos = r_pos; n_sync = r_sync; n_hcrc = r_hcrc; n_fcrc = r_fcrc;
        n_hf = r_hf; n_sbt = r_sbt; n_lhb = r_lhb; n_fibc = r_fibc; n_rch = r_rch;
        n_ts = r_ts; n_flags = r_flags; n_halted = r_halted; n_open = r_open;
        n_mst = r_mst;
        rep_v = 1'b0; rep_kind = eti_fc_pkg::KIND_HEADER; rep_crc = 1'b0;
        rep_fib = 2'd0; rep_ts = 32'd0;
        nst = 7'd0; p = '0; hdr_end = '0; fic_end = '0; mst_end = '0; ficl4 = '0;
        w = 24'd0; is_a = 1'b0; is_c = 1'b0; sync_ok = 1'b0; ts_shift = 32'd0;
        got = {r_rch, i_data_byte};

        if (i_accept && !r_halted) begin
            // Restart frame state on the first byte
            if (i_frame_first) begin
                n_pos = '0; n_hcrc = eti_fc_pkg::CRC_INIT; n_fcrc = eti_fc_pkg::CRC_INIT;
                n_hf = '0; n_sbt = '0; n_lhb = '0; n_fibc = '0; n_rch = '0;
                n_ts = '0; n_flags = '0; n_mst = 1'b0; n_open = 1'b1;
            end
            got = {n_rch, i_data_byte};
            if (n_open && (n_pos < BP_W'(FRAME_BYTES))) begin
                p = POS_W'(n_pos);
                nst = n_hf[22:16];
                ficl4 = !n_hf[23] ? POS_W'(0) :
                        (n_hf[12:11] == 2'd3) ? POS_W'(128) : POS_W'(96);
                hdr_end = POS_W'(12) + POS_W'({nst, 2'b00});
                fic_end = hdr_end + ficl4;
                mst_end = fic_end + POS_W'(n_sbt);
                ts_shift = {n_ts[23:0], i_data_byte};
                n_pos = n_pos + 1'b1;

                if (p == '0) begin
                    if (i_data_byte != eti_fc_pkg::ERR_NONE) begin
                        n_flags[0] = 1'b1;
                        if (!i_continue) begin
                            n_halted = 1'b1;
                            n_open = 1'b0;
                            rep_v = 1'b1;
                            rep_kind = eti_fc_pkg::KIND_ABORT;
                        end
                    end
                end else if (p <= POS_W'(3)) begin
                    n_ts = ts_shift;
                    if (p == POS_W'(3)) begin
                        w = ts_shift[23:0];
                        is_a = (w == eti_fc_pkg::FSYNC_EVEN);
                        is_c = (w == eti_fc_pkg::FSYNC_ODD);
                        case (r_sync)
                            eti_fc_pkg::SYNC_EVEN: sync_ok = is_c;
                            eti_fc_pkg::SYNC_ODD:  sync_ok = is_a;
                            default:               sync_ok = is_a || is_c;
                        endcase
                        n_sync = !sync_ok ? eti_fc_pkg::SYNC_NONE :
                                 is_a ? eti_fc_pkg::SYNC_EVEN : eti_fc_pkg::SYNC_ODD;
                        if (sync_ok) n_flags[1] = 1'b1;
                        n_ts = '0;
                    end
                end else if (p <= POS_W'(7)) begin
                    case (p[1:0])
                        2'd0:    n_hf[31:24] = i_data_byte;
                        2'd1:    n_hf[23:16] = i_data_byte;
                        2'd2:    n_hf[15:8]  = i_data_byte;
                        default: n_hf[7:0]   = i_data_byte;
                    endcase
                    n_hcrc = eti_fc_pkg::crc16_byte(n_hcrc, i_data_byte);
                end else if (p < hdr_end - POS_W'(2)) begin
                    n_hcrc = eti_fc_pkg::crc16_byte(n_hcrc, i_data_byte);
                    if (p < hdr_end - POS_W'(4)) begin
                        if (p[1:0] == 2'd2) n_lhb = i_data_byte[1:0];
                        else if (p[1:0] == 2'd3)
                            n_sbt = n_sbt + {7'd0, n_lhb, i_data_byte, 3'd0};
                    end
                end else if (p == hdr_end - POS_W'(2)) begin
                    n_rch = i_data_byte;
                end else if (p == hdr_end - POS_W'(1)) begin
                    rep_v = 1'b1;
                    rep_kind = eti_fc_pkg::KIND_HEADER;
                    rep_crc = (~n_hcrc == got);
                    n_hcrc = eti_fc_pkg::CRC_INIT;
                    n_fcrc = eti_fc_pkg::CRC_INIT;
                    n_fibc = '0;
                end else if (p < fic_end) begin
                    n_hcrc = eti_fc_pkg::crc16_byte(n_hcrc, i_data_byte);
                    if ((p[4:0] - hdr_end[4:0]) < 5'd30) begin
                        n_fcrc = eti_fc_pkg::crc16_byte(n_fcrc, i_data_byte);
                    end else if ((p[4:0] - hdr_end[4:0]) == 5'd30) begin
                        n_rch = i_data_byte;
                    end else begin
                        rep_v = 1'b1;
                        rep_kind = eti_fc_pkg::KIND_FIB;
                        rep_crc = (~n_fcrc == got);
                        rep_fib = n_fibc[1:0];
                        n_fibc = n_fibc + 1'b1;
                        n_fcrc = eti_fc_pkg::CRC_INIT;
                    end
                end else if (p < mst_end) begin
                    n_hcrc = eti_fc_pkg::crc16_byte(n_hcrc, i_data_byte);
                end else if (p == mst_end) begin
                    n_rch = i_data_byte;
                end else if (p == mst_end + POS_W'(1)) begin
                    n_mst = (~n_hcrc == got);
                end else if (p >= mst_end + POS_W'(4) && p <= mst_end + POS_W'(7)) begin
                    n_ts = ts_shift;
                    if (p == mst_end + POS_W'(7)) begin
                        rep_v = 1'b1;
                        rep_kind = eti_fc_pkg::KIND_END;
                        rep_crc = n_mst;
                        rep_ts = ts_shift;
                        n_open = 1'b0;
                    end
                end
            end
            // Close a frame cut short
            if (i_frame_last && n_open) begin
                rep_v = 1'b1;
                rep_kind = eti_fc_pkg::KIND_END;
                rep_crc = 1'b0;
                rep_fib = 2'd0;
                rep_ts = 32'd0;
                n_open = 1'b0;
            end
        end
    end

    // Build the report from the updated fields
    always_comb begin
        o_push.push = rep_v;
        o_push.report.report_kind  = rep_kind;
        o_push.report.sync_error   = n_flags[0];
        o_push.report.fsync_ok     = n_flags[1];
        o_push.report.frame_count  = n_hf[31:24];
        o_push.report.fic_flag     = n_hf[23];
        o_push.report.stream_count = n_hf[22:16];
        o_push.report.frame_phase  = n_hf[15:13];
        o_push.report.mode_id      = n_hf[12:11];
        o_push.report.frame_length = n_hf[10:0];
        o_push.report.crc_ok       = rep_crc;
        o_push.report.fib_index    = rep_fib;
        o_push.report.timestamp    = rep_ts;
    end

    // Hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_sync <= eti_fc_pkg::SYNC_NONE;
            r_hcrc <= eti_fc_pkg::CRC_INIT; r_fcrc <= eti_fc_pkg::CRC_INIT;
            r_hf <= '0; r_sbt <= '0; r_lhb <= '0; r_fibc <= '0; r_rch <= '0;
            r_ts <= '0; r_flags <= '0; r_halted <= 1'b0; r_open <= 1'b0; r_mst <= 1'b0;
        end else begin
            r_pos <= n_pos; r_sync <= n_sync; r_hcrc <= n_hcrc; r_fcrc <= n_fcrc;
            r_hf <= n_hf; r_sbt <= n_sbt; r_lhb <= n_lhb; r_fibc <= n_fibc; r_rch <= n_rch;
            r_ts <= n_ts; r_flags <= n_flags; r_halted <= n_halted; r_open <= n_open;
            r_mst <= n_mst;
        end
    end

    `ETI_FC_ASSERT_NEXT(a_abort_halts, i_clk, i_rst_n,
        o_push.push && (o_push.report.report_kind == eti_fc_pkg::KIND_ABORT), r_halted)
    `ETI_FC_ASSERT_NEVER(a_halted_silent, i_clk, i_rst_n, r_halted && o_push.push)
    `ETI_FC_ASSERT_NEVER(a_idle_silent, i_clk, i_rst_n, !i_accept && o_push.push)

endmodule

FILE: design/eti_fc_queue.sv
`include "eti_ni_frame_checker_defines.svh"

module eti_fc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  eti_fc_pkg::t_push    i_push,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output eti_fc_pkg::t_report  o_head
);

    localparam int PW = $clog2(eti_fc_pkg::QDEPTH);
    localparam int CW = $clog2(eti_fc_pkg::QDEPTH + 1);

    eti_fc_pkg::t_report r_mem [eti_fc_pkg::QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(eti_fc_pkg::QDEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // Store reports
    always_ff @(posedge i_clk) begin
        if (i_push.push) r_mem[r_wr] <= i_push.report;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_count <= '0;
        end else begin
            if (i_push.push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_count <= r_count + CW'(i_push.push) - CW'(do_pop);
        end
    end

    `ETI_FC_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push.push && o_full)
    `ETI_FC_ASSERT_NEVER(a_count_range, i_clk, i_rst_n,
        r_count > CW'(eti_fc_pkg::QDEPTH))
    `ETI_FC_ASSERT_NEXT(a_head_held, i_clk, i_rst_n, o_valid && !i_pop, o_valid)

endmodule

FILE: design/eti_ni_frame_checker.sv
// Channel  | valid    | stall    | payload
// ---------+----------+----------+---------------------------------------------
// input    | i_valid  | o_stall  | i_data_byte, i_frame_first, i_frame_last
// output   | o_valid  | i_stall  | o_report_kind ... o_timestamp
// config   | i_cfg_wr_en (no stall) | i_cfg_wr_data
//
// One byte per cycle; the classifier updates frame state and CRCs in the cycle
// the byte is taken, and the report is registered into a 4-entry queue read at its head.
// Input stalls only while that queue is full.
// Synchronous active-low reset clears all frame state; no clearing pass.
module eti_ni_frame_checker #(
    parameter int FRAME_BYTES = 6144
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_first,
    input  logic        i_frame_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_report_kind,
    output logic        o_sync_error,
    output logic        o_fsync_ok,
    output logic [7:0]  o_frame_count,
    output logic        o_fic_flag,
    output logic [6:0]  o_stream_count,
    output logic [2:0]  o_frame_phase,
    output logic [1:0]  o_mode_id,
    output logic [10:0] o_frame_length,
    output logic        o_crc_ok,
    output logic [1:0]  o_fib_index,
    output logic [31:0] o_timestamp
);

    logic                r_continue;
    logic                full;
    eti_fc_pkg::t_push   push;
    eti_fc_pkg::t_report head;

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_continue <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_continue <= i_cfg_wr_data;
        end
    end

    assign o_stall = full;

    eti_fc_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (i_valid && !full),
        .i_data_byte   (i_data_byte),
        .i_frame_first (i_frame_first),
        .i_frame_last  (i_frame_last),
        .i_continue    (r_continue),
        .o_push        (push)
    );

    eti_fc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_full  (full),
        .o_valid (o_valid),
        .o_head  (head)
    );

    // Drive result ports
    assign o_report_kind  = head.report_kind;
    assign o_sync_error   = head.sync_error;
    assign o_fsync_ok     = head.fsync_ok;
    assign o_frame_count  = head.frame_count;
    assign o_fic_flag     = head.fic_flag;
    assign o_stream_count = head.stream_count;
    assign o_frame_phase  = head.frame_phase;
    assign o_mode_id      = head.mode_id;
    assign o_frame_length = head.frame_length;
    assign o_crc_ok       = head.crc_ok;
    assign o_fib_index    = head.fib_index;
    assign o_timestamp    = head.timestamp;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAME_LEN = 6144;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_frame_first;
    logic        i_frame_last;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_report_kind;
    logic        o_sync_error;
    logic        o_fsync_ok;
    logic [7:0]  o_frame_count;
    logic        o_fic_flag;
    logic [6:0]  o_stream_count;
    logic [2:0]  o_frame_phase;
    logic [1:0]  o_mode_id;
    logic [10:0] o_frame_length;
    logic        o_crc_ok;
    logic [1:0]  o_fib_index;
    logic [31:0] o_timestamp;

    eti_ni_frame_checker #(.FRAME_BYTES(FRAME_LEN)) uut (.*);

    // Byte stream entry for the checker
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_byte;

    // Directed row: a byte plus an optional typed-in report
    typedef struct {
        t_byte               b;
        bit                  has_fixed;
        eti_fc_pkg::t_report fixed;
    } t_row;

    eti_fc_pkg::t_report report_q[$];
    t_byte               byte_q[$];

    // Append to the expected and stimulus queues
    function automatic void add_report(input eti_fc_pkg::t_report r);
        report_q.insert(report_q.size(), r);
    endfunction

    function automatic void add_byte(input t_byte x);
        byte_q.insert(byte_q.size(), x);
    endfunction

    function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    // Predictor state
    bit          cont_on_err;
    int unsigned pos;
    logic [1:0]  sync_hist;
    logic [15:0] run_crc;
    logic [15:0] fib_crc;
    logic [31:0] fc_word;
    logic [19:0] mst_bytes;
    logic [1:0]  len_hi;
    logic [7:0]  fib_cnt;
    logic [7:0]  crc_hi;
    logic [31:0] ts_shift;
    logic [1:0]  flags;
    bit          is_halted;
    bit          is_open;
    bit          mst_ok;

    int  mismatches;
    int  reports_seen;
    int  bytes_sent;
    int  idle_send_pct;
    int  idle_recv_pct;
    bit  hold_recv;
    int  quiet_cycles;
    bit  timed_out;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic eti_fc_pkg::t_report make_report(input logic [1:0] kind, input bit ok,
                                            input logic [1:0] fib, input logic [31:0] ts);
        eti_fc_pkg::t_report r;
        r.report_kind  = kind;
        r.sync_error   = flags[0];
        r.fsync_ok     = flags[1];
        r.frame_count  = fc_word[31:24];
        r.fic_flag     = fc_word[23];
        r.stream_count = fc_word[22:16];
        r.frame_phase  = fc_word[15:13];
        r.mode_id      = fc_word[12:11];
        r.frame_length = fc_word[10:0];
        r.crc_ok       = ok;
        r.fib_index    = fib;
        r.timestamp    = ts;
        return r;
    endfunction

    function automatic void open_frame();
        pos = 0; run_crc = 16'hFFFF; fib_crc = 16'hFFFF; fc_word = '0;
        mst_bytes = '0; len_hi = '0; fib_cnt = '0; crc_hi = '0; ts_shift = '0;
        flags = '0; mst_ok = 1'b0;
    endfunction

    function automatic void predictor_reset();
        cont_on_err = 1'b0;
        open_frame();
        sync_hist = eti_fc_pkg::SYNC_NONE; is_halted = 1'b0; is_open = 1'b0;
    endfunction

    // Advance the frame model by one byte; queue any report it causes
    function automatic void predict_byte(input t_byte x);
        int unsigned nst, ficl, hdr_end, fic_end, mst_end, p, j;
        bit have;
        eti_fc_pkg::t_report r;
        logic [23:0] w;
        bit a, c, ok;
        have = 0;
        if (is_halted) return;
        if (x.first) begin
            open_frame();
            is_open = 1'b1;
        end
        if (!is_open) return;
        if (pos < FRAME_LEN) begin
            p = pos;
            nst = fc_word[22:16];
            ficl = fc_word[23] ? (fc_word[12:11] == 2'd3 ? 32 : 24) : 0;
            hdr_end = 12 + 4 * nst;
            fic_end = hdr_end + 4 * ficl;
            mst_end = fic_end + mst_bytes;
            pos = p + 1;
            if (p == 0) begin
                if (x.data != eti_fc_pkg::ERR_NONE) begin
                    flags[0] = 1'b1;
                    if (!cont_on_err) begin
                        is_halted = 1'b1;
                        is_open = 1'b0;
                        add_report(make_report(eti_fc_pkg::KIND_ABORT, 0, 0, 0));
                        return;
                    end
                end
            end else if (p <= 3) begin
                ts_shift = {ts_shift[23:0], x.data};
                if (p == 3) begin
                    w = ts_shift[23:0];
                    a = (w == eti_fc_pkg::FSYNC_EVEN);
                    c = (w == eti_fc_pkg::FSYNC_ODD);
                    if (sync_hist == eti_fc_pkg::SYNC_EVEN) ok = c;
                    else if (sync_hist == eti_fc_pkg::SYNC_ODD) ok = a;
                    else ok = a || c;
                    sync_hist = ok ? (a ? eti_fc_pkg::SYNC_EVEN : eti_fc_pkg::SYNC_ODD) :
                                eti_fc_pkg::SYNC_NONE;
                    if (ok) flags[1] = 1'b1;
                    ts_shift = '0;
                end
            end else if (p <= 7) begin
                fc_word = fc_word | (32'(x.data) << (8 * (7 - p)));
                run_crc = crc_step(run_crc, x.data);
            end else if (p < hdr_end - 2) begin
                run_crc = crc_step(run_crc, x.data);
                if (p < 8 + 4 * nst) begin
                    if (((p - 8) & 3) == 2) len_hi = x.data[1:0];
                    else if (((p - 8) & 3) == 3)
                        mst_bytes = mst_bytes + 20'({len_hi, x.data}) * 20'd8;
                end
            end else if (p == hdr_end - 2) begin
                crc_hi = x.data;
            end else if (p == hdr_end - 1) begin
                r = make_report(eti_fc_pkg::KIND_HEADER, (~run_crc) == {crc_hi, x.data}, 0, 0);
                have = 1;
                run_crc = 16'hFFFF; fib_crc = 16'hFFFF; fib_cnt = '0;
            end else if (p < fic_end) begin
                j = (p - hdr_end) & 31;
                run_crc = crc_step(run_crc, x.data);
                if (j < 30) fib_crc = crc_step(fib_crc, x.data);
                else if (j == 30) crc_hi = x.data;
                else begin
                    r = make_report(eti_fc_pkg::KIND_FIB, (~fib_crc) == {crc_hi, x.data},
                                    fib_cnt[1:0], 0);
                    have = 1;
                    fib_cnt++;
                    fib_crc = 16'hFFFF;
                end
            end else if (p < mst_end) begin
                run_crc = crc_step(run_crc, x.data);
            end else if (p == mst_end) begin
                crc_hi = x.data;
            end else if (p == mst_end + 1) begin
                mst_ok = ((~run_crc) == {crc_hi, x.data});
            end else if (p >= mst_end + 4 && p <= mst_end + 7) begin
                ts_shift = {ts_shift[23:0], x.data};
                if (p == mst_end + 7) begin
                    r = make_report(eti_fc_pkg::KIND_END, mst_ok, 0, ts_shift);
                    have = 1;
                    is_open = 1'b0;
                end
            end
        end
        // A cut-short frame replaces any report of the same byte
        if (x.last && is_open) begin
            r = make_report(eti_fc_pkg::KIND_END, 0, 0, 0);
            have = 1;
            is_open = 1'b0;
        end
        if (have) add_report(r);
    endfunction

    // Append a well-formed frame, optionally corrupting one CRC or cutting it short
    task automatic build_frame(input bit odd_sync, input int nst, input bit ficf,
                               input logic [1:0] mid, input int bad_sel, input int cut_at,
                               input logic [7:0] err_byte);
        logic [7:0] f[$];
        logic [15:0] c, cm;
        logic [23:0] fs;
        logic [31:0] fc;
        int ficl, slen, hstart, total;
        t_byte x;
        fs = odd_sync ? eti_fc_pkg::FSYNC_ODD : eti_fc_pkg::FSYNC_EVEN;
        append_byte(f, err_byte);
        append_byte(f, fs[23:16]); append_byte(f, fs[15:8]); append_byte(f, fs[7:0]);
        fc = {8'($urandom), ficf, 7'(nst), 3'($urandom), mid, 11'($urandom)};
        for (int i = 3; i >= 0; i--) append_byte(f, fc[8*i +: 8]);
        for (int s = 0; s < nst; s++) begin
            slen = $urandom_range(0, 3);
            append_byte(f, 8'($urandom)); append_byte(f, 8'($urandom));
            append_byte(f, {6'($urandom), 2'(slen >> 8)}); append_byte(f, 8'(slen));
        end
        append_byte(f, 8'($urandom)); append_byte(f, 8'($urandom));
        c = 16'hFFFF;
        for (int i = 4; i < f.size(); i++) c = crc_step(c, f[i]);
        c = ~c ^ (bad_sel == 0 ? 16'h0001 : 16'h0);
        append_byte(f, c[15:8]); append_byte(f, c[7:0]);
        cm = 16'hFFFF;
        ficl = ficf ? (mid == 2'd3 ? 4 : 3) : 0;
        for (int k = 0; k < ficl; k++) begin
            hstart = f.size();
            for (int i = 0; i < 30; i++) append_byte(f, 8'($urandom));
            c = 16'hFFFF;
            for (int i = hstart; i < hstart + 30; i++) c = crc_step(c, f[i]);
            c = ~c ^ (bad_sel == 1 ? 16'h8000 : 16'h0);
            append_byte(f, c[15:8]); append_byte(f, c[7:0]);
            for (int i = hstart; i < hstart + 32; i++) cm = crc_step(cm, f[i]);
        end
        total = 0;
        for (int s = 0; s < nst; s++) total += f[8 + 4*s + 3] + 256 * f[8 + 4*s + 2][1:0];
        for (int i = 0; i < total * 8; i++) begin
            append_byte(f, 8'($urandom));
            cm = crc_step(cm, f[f.size() - 1]);
        end
        cm = ~cm ^ (bad_sel == 2 ? 16'h0100 : 16'h0);
        append_byte(f, cm[15:8]); append_byte(f, cm[7:0]);
        append_byte(f, 8'($urandom)); append_byte(f, 8'($urandom));
        for (int i = 0; i < 4; i++) append_byte(f, 8'($urandom));
        if (cut_at > 0 && cut_at < f.size()) f = f[0:cut_at - 1];
        for (int i = 0; i < f.size(); i++) begin
            x.data = f[i]; x.first = (i == 0); x.last = (i == f.size() - 1);
            add_byte(x);
        end
    endtask

    // Drive queued bytes with random gaps until the queue empties
    task automatic send_bytes();
        t_byte x;
        while (byte_q.size() > 0) begin
            if ($urandom_range(0, 99) < idle_send_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                x = byte_q.pop_front();
                i_valid <= 1'b1;
                i_data_byte <= x.data;
                i_frame_first <= x.first;
                i_frame_last <= x.last;
                predict_byte(x);
                bytes_sent++;
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (report_q.size() > 0 && !timed_out) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input bit v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cont_on_err = v;
        @(posedge i_clk);
    endtask

    // Receiver stall generation
    always @(posedge i_clk) begin
        if (hold_recv) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(0, 99) < idle_recv_pct);
    end

    // Compare each transaction with the oldest expected report
    always @(posedge i_clk) begin
        eti_fc_pkg::t_report got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_report_kind, o_sync_error, o_fsync_ok, o_frame_count, o_fic_flag,
                    o_stream_count, o_frame_phase, o_mode_id, o_frame_length, o_crc_ok,
                    o_fib_index, o_timestamp};
            reports_seen++;
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected report %p", got);
            end else begin
                want = report_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            timed_out <= 1'b1;
            $display("** eti_ni_frame_checker: FAILED **");
            $finish;
        end
    end

    // Directed rows, the abort case with its typed-in report
    task automatic run_directed();
        t_row rows[$];
        t_row row;
        eti_fc_pkg::t_report ab;
        // Header-only frame with zero streams and no FIC
        build_frame(0, 0, 0, 2'd0, -1, 0, eti_fc_pkg::ERR_NONE);
        // Bad header CRC, then an FSYNC that repeats
        build_frame(0, 0, 0, 2'd3, 0, 0, eti_fc_pkg::ERR_NONE);
        // Cut short mid-header
        build_frame(1, 1, 0, 2'd1, -1, 6, eti_fc_pkg::ERR_NONE);
        send_bytes();
        wait_drain();
        // Error byte with continue off: abort, then halt until reset
        ab = '0;
        ab.report_kind = eti_fc_pkg::KIND_ABORT;
        ab.sync_error = 1'b1;
        row.b = '{8'h00, 1'b1, 1'b0}; row.has_fixed = 1; row.fixed = ab;
        rows.insert(rows.size(), row);
        row.b = '{8'hFF, 1'b1, 1'b1}; row.has_fixed = 0;
        rows.insert(rows.size(), row);
        foreach (rows[i]) begin
            add_byte(rows[i].b);
            send_bytes();
            if (rows[i].has_fixed && (report_q.size() != 1 || report_q[0] !== rows[i].fixed)) begin
                mismatches++;
                $display("abort prediction differs from table row %0d", i);
            end
            @(posedge i_clk);
        end
        wait_drain();
    endtask

    initial begin
        int phase;
        t_byte rb;
        i_rst_n = 1'b0; i_cfg_wr_en = 1'b0; i_cfg_wr_data = 1'b0; i_valid = 1'b0;
        i_data_byte = '0; i_frame_first = 1'b0; i_frame_last = 1'b0; i_stall = 1'b0;
        idle_send_pct = 0; idle_recv_pct = 0; hold_recv = 0; timed_out = 0;
        mismatches = 0; reports_seen = 0; bytes_sent = 0; quiet_cycles = 0;
        predictor_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Halting case is final for the predictor until reset, so run it last;
        // first cover the continue setting both ways
        write_cfg(1'b1);
        build_frame(0, 2, 0, 2'd3, -1, 0, 8'h00);
        build_frame(1, 1, 1, 2'd3, 1, 0, eti_fc_pkg::ERR_NONE);
        build_frame(0, 1, 0, 2'd0, 2, 0, eti_fc_pkg::ERR_NONE);
        // Stray bytes outside a frame, then a frame dropped by a new first byte
        add_byte('{8'hAA, 1'b0, 1'b0});
        add_byte('{eti_fc_pkg::ERR_NONE, 1'b1, 1'b0});
        // Long receiver hold-off while bytes keep coming, so the queue fills
        fork
            begin
                hold_recv = 1;
                repeat (300) @(posedge i_clk);
                hold_recv = 0;
            end
        join_none
        send_bytes();
        wait_drain();
        write_cfg(1'b0);

        // Random phases of well-formed and broken frames
        for (phase = 0; phase < 4 && !timed_out; phase++) begin
            case (phase)
                0: begin idle_send_pct = 0;  idle_recv_pct = 0;  end
                1: begin idle_send_pct = 72; idle_recv_pct = 0;  end
                2: begin idle_send_pct = 0;  idle_recv_pct = 72; end
                default: begin idle_send_pct = 15; idle_recv_pct = 15; end
            endcase
            if (phase == 1) begin
                // Long receiver hold-off while bytes keep coming
                fork
                    begin
                        hold_recv = 1;
                        repeat (300) @(posedge i_clk);
                        hold_recv = 0;
                    end
                join_none
            end
            build_frame($urandom_range(0, 1), $urandom_range(0, 2), 1'b0,
                        2'($urandom), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : -1,
                        ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 0,
                        eti_fc_pkg::ERR_NONE);
            // Stray bytes; a first byte always carries a clean error byte
            for (int n = 0; n < 6; n++) begin
                rb.first = 1'($urandom);
                rb.last = 1'($urandom);
                rb.data = rb.first ? eti_fc_pkg::ERR_NONE : 8'($urandom);
                add_byte(rb);
            end
            send_bytes();
            wait_drain();
            write_cfg(phase[0]);
        end
        write_cfg(1'b0);
        idle_send_pct = 0; idle_recv_pct = 0;
        run_directed();

        $display("covered %0d bytes, %0d reports: framing, FIB and stream CRCs,", bytes_sent,
                 reports_seen);
        $display("cut-short and dropped frames, sync errors with and without abort");
        if (mismatches == 0 && report_q.size() == 0)
            $display("** eti_ni_frame_checker: PASSED **");
        else
            $display("** eti_ni_frame_checker: FAILED **");
        $finish;
    end

endmodule
